// ----- design/pps_pkg.sv -----
// Shared types and constants for the PWM pattern sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pps_pkg;

  typedef enum logic [2:0] {
    PH_RAMP_UP   = 3'd0,
    PH_HOLD1     = 3'd1,
    PH_HOLD2     = 3'd2,
    PH_HOLD3     = 3'd3,
    PH_DIP1      = 3'd4,
    PH_DIP2      = 3'd5,
    PH_RAMP_DOWN = 3'd6,
    PH_PAUSE     = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    REG_RAMP_STEP   = 2'd0,
    REG_HOLD_TICKS  = 2'd1,
    REG_PAUSE_TICKS = 2'd2,
    REG_FULL_SCALE  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [6:0] ramp_step;
    logic [7:0] hold_ticks;
    logic [7:0] pause_ticks;
    logic [7:0] full_scale;
  } cfg_t;

  // What the sequencer emits for one active tick.
  typedef struct packed {
    logic [6:0] duty;
    phase_t     phase;
  } emit_t;

  localparam logic [6:0] DUTY_FULL = 7'd100;
  localparam logic [7:0] CMP_FULL  = 8'hFF;

  // x / 100 == (x * 5243) >> 19 exactly for x < 2^15
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [6:0] RST_RAMP_STEP   = 7'd5;
  localparam logic [7:0] RST_HOLD_TICKS  = 8'd10;
  localparam logic [7:0] RST_PAUSE_TICKS = 8'd20;
  localparam logic [7:0] RST_FULL_SCALE  = 8'd255;

endpackage

// ----- design/pps_seq.sv -----
// Pattern phase sequencer: phase, duty level and tick counter.
// Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_seq import pps_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  cfg_t  cfg,
  output emit_t emit
);

  phase_t     phase, phase_next;
  logic [6:0] duty_level, duty_level_next;
  logic [7:0] phase_ticks, phase_ticks_next;

  logic [6:0] step;
  logic [7:0] ticks_inc;
  logic [7:0] ramp_sum;
  logic       hold_done, pause_done;

  assign step       = (cfg.ramp_step == 7'd0) ? 7'd1 : cfg.ramp_step;
  assign ticks_inc  = phase_ticks + 8'd1;
  assign ramp_sum   = {1'b0, duty_level} + {1'b0, step};
  // a limit of zero is met at once, same as one
  assign hold_done  = (ticks_inc >= cfg.hold_ticks);
  assign pause_done = (ticks_inc >= cfg.pause_ticks);

  always_comb begin
    phase_next       = phase;
    duty_level_next  = duty_level;
    phase_ticks_next = phase_ticks;
    unique case (phase)
      PH_RAMP_UP: begin
        if (duty_level >= DUTY_FULL) begin
          phase_next       = PH_HOLD1;
          phase_ticks_next = 8'd0;
        end else if (ramp_sum > {1'b0, DUTY_FULL}) begin
          duty_level_next = DUTY_FULL;
        end else begin
          duty_level_next = ramp_sum[6:0];
        end
      end
      PH_HOLD1, PH_HOLD2, PH_HOLD3, PH_DIP1, PH_DIP2: begin
        phase_ticks_next = ticks_inc;
        if (hold_done) begin
          phase_ticks_next = 8'd0;
          unique case (phase)
            PH_HOLD1: phase_next = PH_DIP1;
            PH_HOLD2: phase_next = PH_DIP2;
            PH_DIP1:  phase_next = PH_HOLD2;
            PH_DIP2:  phase_next = PH_HOLD3;
            default:  phase_next = PH_RAMP_DOWN;
          endcase
        end
      end
      PH_RAMP_DOWN: begin
        if (duty_level == 7'd0) begin
          phase_next       = PH_PAUSE;
          phase_ticks_next = 8'd0;
        end else if (duty_level > step) begin
          duty_level_next = duty_level - step;
        end else begin
          duty_level_next = 7'd0;
        end
      end
      default: begin
        phase_ticks_next = ticks_inc;
        if (pause_done) begin
          phase_ticks_next = 8'd0;
          phase_next       = PH_RAMP_UP;
          duty_level_next  = 7'd0;
        end
      end
    endcase
  end

  always_comb begin
    emit.phase = phase;
    unique case (phase)
      PH_RAMP_UP, PH_RAMP_DOWN:    emit.duty = duty_level;
      PH_HOLD1, PH_HOLD2, PH_HOLD3: emit.duty = DUTY_FULL;
      default:                     emit.duty = 7'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_RAMP_UP;
      duty_level  <= 7'd0;
      phase_ticks <= 8'd0;
    end else if (advance) begin
      phase       <= phase_next;
      duty_level  <= duty_level_next;
      phase_ticks <= phase_ticks_next;
    end
  end

endmodule

// ----- design/pwm_pattern_sequencer_top.sv -----
// PWM pattern sequencer top: config registers, two-stage result pipeline.
// Depends on pps_pkg and pps_seq.
// An accepted word is registered in stage 1, then in stage 2 as its result word.
// Throughput: one word per cycle unless out_stall holds; stage 1 holds the
// duty x full_scale product, stage 2 the divide-by-100 by reciprocal multiply.
// Reset: synchronous; config returns to defaults, pattern restarts at ramp up.
`timescale 1ns / 1ps

module pwm_pattern_sequencer_top import pps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       tick,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] compare_value,
  output logic       output_enabled,
  output logic       led_off_request,
  output logic [6:0] duty_pct,
  output logic [2:0] phase_now
);

  cfg_t  cfg;
  emit_t emit;

  logic        adv_a, adv_b, take;
  logic        valid_a, fresh_a;
  emit_t       emit_a;
  logic [14:0] prod_a;
  logic [27:0] scaled;
  logic [7:0]  cmp_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_step   <= RST_RAMP_STEP;
      cfg.hold_ticks  <= RST_HOLD_TICKS;
      cfg.pause_ticks <= RST_PAUSE_TICKS;
      cfg.full_scale  <= RST_FULL_SCALE;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_RAMP_STEP:   cfg.ramp_step   <= wr_data[6:0];
        REG_HOLD_TICKS:  cfg.hold_ticks  <= wr_data;
        REG_PAUSE_TICKS: cfg.pause_ticks <= wr_data;
        REG_FULL_SCALE:  cfg.full_scale  <= wr_data;
      endcase
    end
  end

  assign adv_b    = !out_valid || !out_stall;
  assign adv_a    = !valid_a || adv_b;
  assign in_stall = !adv_a;
  assign take     = in_valid && adv_a;

  pps_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .advance (take && tick),
    .cfg     (cfg),
    .emit    (emit)
  );

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (adv_a) begin
      valid_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fresh_a <= tick;
      emit_a  <= emit;
      prod_a  <= {8'd0, emit.duty} * {7'd0, cfg.full_scale};
    end
  end

  // stage 2: divide by 100, with the zero and full-duty cases forced
  assign scaled = {13'd0, prod_a} * {15'd0, RECIP_100};

  always_comb begin
    if (emit_a.duty == 7'd0) begin
      cmp_b = 8'd0;
    end else if (emit_a.duty >= DUTY_FULL) begin
      cmp_b = CMP_FULL;
    end else begin
      cmp_b = scaled[RECIP_SHIFT +: 8];
    end
  end

  // an idle tick leaves the result registers holding the last emitted word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      compare_value   <= 8'd0;
      output_enabled  <= 1'b0;
      led_off_request <= 1'b1;
      duty_pct        <= 7'd0;
      phase_now       <= 3'd0;
    end else if (adv_b) begin
      out_valid <= valid_a;
      if (valid_a && fresh_a) begin
        compare_value   <= cmp_b;
        output_enabled  <= (emit_a.duty != 7'd0);
        led_off_request <= (emit_a.duty == 7'd0);
        duty_pct        <= emit_a.duty;
        phase_now       <= emit_a.phase;
      end
    end
  end

endmodule

// ----- design/pps_check.sv -----
// Port-level checker for the PWM pattern sequencer, bound to the top level.
// Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_check import pps_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] compare_value,
  input logic       output_enabled,
  input logic       led_off_request,
  input logic [6:0] duty_pct,
  input logic [2:0] phase_now
);

  a_zero_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (led_off_request == (duty_pct == 7'd0)) &&
                  (output_enabled != led_off_request))
    else $error("enable/off flags disagree with duty");

  a_full_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && duty_pct >= DUTY_FULL |-> compare_value == CMP_FULL &&
                                           duty_pct == DUTY_FULL)
    else $error("full duty must give full compare");

  a_dark_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && (phase_now == PH_DIP1 || phase_now == PH_DIP2 ||
                  phase_now == PH_PAUSE) |-> led_off_request && compare_value == 8'd0)
    else $error("dip or pause phase with LED on");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(compare_value) &&
                               $stable(duty_pct) && $stable(phase_now))
    else $error("stalled result word changed");

endmodule

bind pwm_pattern_sequencer_top pps_check u_pps_check (.*);

// ----- tb/sv/pwm_pattern_sequencer_top_tb.sv -----
// Self-checking testbench for pwm_pattern_sequencer_top: directed ticks, then random
// tick streams under several register settings and handshake idling modes.
// Depends on pps_pkg and the design sources of pwm_pattern_sequencer_top.
`timescale 1ns / 1ps

module pwm_pattern_sequencer_top_tb;
  import pps_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int CHUNKS       = 8;
  localparam int CHUNK_WORDS  = 180;
  localparam int MAX_REPORTED = 10;

  typedef struct packed {
    logic [7:0] compare_value;
    logic       output_enabled;
    logic       led_off_request;
    logic [6:0] duty_pct;
    logic [2:0] phase_now;
  } pattern_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       wr_en = 1'b0;
  logic [1:0] wr_index = '0;
  logic [7:0] wr_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       tick = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] compare_value;
  logic       output_enabled;
  logic       led_off_request;
  logic [6:0] duty_pct;
  logic [2:0] phase_now;

  pwm_pattern_sequencer_top u_top (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .tick(tick),
    .out_valid(out_valid), .out_stall(out_stall),
    .compare_value(compare_value), .output_enabled(output_enabled),
    .led_off_request(led_off_request), .duty_pct(duty_pct),
    .phase_now(phase_now)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of registers and pattern state
  logic [6:0]    cfg_ramp_step;
  logic [7:0]    cfg_hold_ticks;
  logic [7:0]    cfg_pause_ticks;
  logic [7:0]    cfg_full_scale;
  phase_t        seq_phase;
  int unsigned   seq_duty;
  logic [7:0]    seq_count;
  pattern_word_t last_word;

  logic          tick_queue[$];
  pattern_word_t expected_words[$];
  int            words_in_flight = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            mismatches = 0;
  int            words_checked = 0;
  int            ticks_sent = 0;
  int            settings_loaded = 0;
  int            cycle_count = 0;
  pattern_word_t want_word;
  pattern_word_t got_word;

  function automatic pattern_word_t word_for(int unsigned duty, phase_t ph);
    pattern_word_t w;
    int unsigned scaled;
    scaled = (duty * cfg_full_scale) / 100;
    if (duty == 0) w.compare_value = 8'd0;
    else if (duty >= DUTY_FULL) w.compare_value = CMP_FULL;
    else w.compare_value = scaled[7:0];
    w.output_enabled  = (duty != 0);
    w.led_off_request = (duty == 0);
    w.duty_pct        = (duty > DUTY_FULL) ? DUTY_FULL : duty[6:0];
    w.phase_now       = ph;
    return w;
  endfunction

  // counts ticks in a hold/dip/pause phase; a limit of 0 behaves as 1
  function automatic logic count_up(logic [7:0] lim);
    seq_count = seq_count + 8'd1;
    return seq_count >= lim;
  endfunction

  function automatic pattern_word_t pattern_step(logic adv);
    int unsigned step;
    if (adv) begin
      step = (cfg_ramp_step == 0) ? 1 : cfg_ramp_step;
      case (seq_phase)
        PH_RAMP_UP: begin
          last_word = word_for(seq_duty, PH_RAMP_UP);
          if (seq_duty >= DUTY_FULL) begin
            seq_phase = PH_HOLD1;
            seq_count = '0;
          end else begin
            seq_duty = (seq_duty + step > DUTY_FULL) ? DUTY_FULL : seq_duty + step;
          end
        end
        PH_HOLD1, PH_HOLD2, PH_HOLD3: begin
          last_word = word_for(DUTY_FULL, seq_phase);
          if (count_up(cfg_hold_ticks)) begin
            seq_count = '0;
            if (seq_phase == PH_HOLD1) seq_phase = PH_DIP1;
            else if (seq_phase == PH_HOLD2) seq_phase = PH_DIP2;
            else seq_phase = PH_RAMP_DOWN;
          end
        end
        PH_DIP1, PH_DIP2: begin
          last_word = word_for(0, seq_phase);
          if (count_up(cfg_hold_ticks)) begin
            seq_count = '0;
            if (seq_phase == PH_DIP1) seq_phase = PH_HOLD2;
            else seq_phase = PH_HOLD3;
          end
        end
        PH_RAMP_DOWN: begin
          last_word = word_for(seq_duty, PH_RAMP_DOWN);
          if (seq_duty == 0) begin
            seq_phase = PH_PAUSE;
            seq_count = '0;
          end else begin
            seq_duty = (seq_duty > step) ? seq_duty - step : 0;
          end
        end
        default: begin
          last_word = word_for(0, PH_PAUSE);
          if (count_up(cfg_pause_ticks)) begin
            seq_count = '0;
            seq_phase = PH_RAMP_UP;
            seq_duty  = 0;
          end
        end
      endcase
    end
    return last_word;
  endfunction

  task automatic reset_pattern();
    cfg_ramp_step   = RST_RAMP_STEP;
    cfg_hold_ticks  = RST_HOLD_TICKS;
    cfg_pause_ticks = RST_PAUSE_TICKS;
    cfg_full_scale  = RST_FULL_SCALE;
    seq_phase       = PH_RAMP_UP;
    seq_duty        = 0;
    seq_count       = '0;
    last_word       = word_for(0, PH_RAMP_UP);
  endtask

  task automatic write_reg(reg_index_t idx, logic [7:0] val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    case (idx)
      REG_RAMP_STEP:   cfg_ramp_step   = val[6:0];
      REG_HOLD_TICKS:  cfg_hold_ticks  = val;
      REG_PAUSE_TICKS: cfg_pause_ticks = val;
      default:         cfg_full_scale  = val;
    endcase
  endtask

  task automatic load_pattern_cfg(logic [7:0] ramp, logic [7:0] hold,
                                  logic [7:0] pause, logic [7:0] fs);
    write_reg(REG_RAMP_STEP, ramp);
    write_reg(REG_HOLD_TICKS, hold);
    write_reg(REG_PAUSE_TICKS, pause);
    write_reg(REG_FULL_SCALE, fs);
    @(posedge clk);
    wr_en <= 1'b0;
    settings_loaded++;
  endtask

  task automatic queue_tick(logic t);
    words_in_flight++;
    tick_queue.push_back(t);
  endtask

  task automatic queue_random_ticks(int n);
    for (int i = 0; i < n; i++) queue_tick($urandom_range(99) < 85);
  endtask

  // every word gives a result, so a drained pipe is idle after the latency
  task automatic drain_pattern();
    wait (words_in_flight == 0);
    repeat (4) @(posedge clk);
  endtask

  // driver: one tick word per handshake, held while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_words.push_back(pattern_step(tick));
        ticks_sent += tick;
      end
      if (!(in_valid && in_stall)) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          tick     <= tick_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        got_word = {compare_value, output_enabled, led_off_request, duty_pct, phase_now};
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED)
            $display("%0t: result word with nothing predicted: %h", $realtime, got_word);
        end else begin
          want_word = expected_words.pop_front();
          words_in_flight--;
          words_checked++;
          if (got_word.compare_value   !== want_word.compare_value   ||
              got_word.output_enabled  !== want_word.output_enabled  ||
              got_word.led_off_request !== want_word.led_off_request ||
              got_word.duty_pct        !== want_word.duty_pct        ||
              got_word.phase_now       !== want_word.phase_now) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
              $display("%0t: word %0d expected cmp=%0d en=%0d off=%0d duty=%0d ph=%0d",
                       $realtime, words_checked,
                       want_word.compare_value, want_word.output_enabled,
                       want_word.led_off_request, want_word.duty_pct,
                       want_word.phase_now);
              $display("    got cmp=%0d en=%0d off=%0d duty=%0d ph=%0d",
                       got_word.compare_value, got_word.output_enabled,
                       got_word.led_off_request, got_word.duty_pct,
                       got_word.phase_now);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count, words_in_flight);
      $display("** pwm_pattern_sequencer_top: FAILED **");
      $finish;
    end
  end

  initial begin
    reset_pattern();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // idle ticks return the reset word, then ramp from zero duty
    queue_tick(1'b0);
    queue_tick(1'b0);
    queue_tick(1'b1);
    queue_tick(1'b1);
    queue_tick(1'b1);
    queue_tick(1'b0);
    queue_tick(1'b1);
    drain_pattern();

    // step 30 overshoots 100 and undershoots 0; zero counts and zero full scale
    load_pattern_cfg(8'd30, 8'd0, 8'd0, 8'd0);
    for (int i = 0; i < 18; i++) queue_tick(1'b1);
    drain_pattern();

    for (int k = 0; k < CHUNKS; k++) begin
      if (k < 3) begin
        send_idle_pct  = 10;
        recv_stall_pct = 78;
      end else if (k < 6) begin
        send_idle_pct  = 78;
        recv_stall_pct = 10;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      case (k)
        // bit 7 of the step write is dropped, leaving a zero step
        1: load_pattern_cfg(8'h80, 8'd1, 8'd1, 8'($urandom_range(255)));
        3: load_pattern_cfg(8'hFF, 8'd1, 8'd255, 8'd255);
        5: load_pattern_cfg(8'd100, 8'd255, 8'd1, 8'd1);
        6: load_pattern_cfg(8'd1, 8'd0, 8'd0, 8'($urandom_range(1, 254)));
        default: load_pattern_cfg({1'($urandom_range(1)), 7'($urandom_range(1, 40))},
                                  8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                                  8'($urandom_range(255)));
      endcase
      queue_random_ticks(CHUNK_WORDS / 2);
      drain_pattern();
      queue_random_ticks(CHUNK_WORDS / 2);
      drain_pattern();
    end

    if (expected_words.size() != 0) mismatches++;
    $display("checked %0d result words from %0d advancing ticks", words_checked, ticks_sent);
    $display("over %0d register settings and three idling modes", settings_loaded);
    if (mismatches == 0) begin
      $display("** pwm_pattern_sequencer_top: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** pwm_pattern_sequencer_top: FAILED **");
    end
    $finish;
  end

endmodule
